[design/euv_pkg.sv]
// Shared constants and types for the encoder unwrap and velocity block.
// No dependencies; compile first.
package euv_pkg;

    localparam int EUV_ANGLE_BITS = 12;
    localparam int ANGLE_SAMPLE_W = 12;
    localparam int INTERVAL_W     = 16;
    localparam int POSITION_W     = 32;
    localparam int SPEED_W        = 22;
    localparam int SCALE_W        = 10;
    localparam int SPEED_CALC_W   = 32;

    localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(1000);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic load_out;
    } euv_cmd_t;

endpackage

[design/euv_in_if.sv]
// Input channel: angle sample and interval with valid/ready.
// Depends on euv_pkg.
interface euv_in_if
    import euv_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ANGLE_SAMPLE_W-1:0] angle_sample;
    logic [INTERVAL_W-1:0]     interval_ms;

    modport source (output valid, output angle_sample, output interval_ms, input ready);
    modport sink (input valid, input angle_sample, input interval_ms, output ready);
endinterface

[design/euv_out_if.sv]
// Output channel: angle echo, multi-turn position and speed with valid/ready.
// Depends on euv_pkg.
interface euv_out_if
    import euv_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [ANGLE_SAMPLE_W-1:0]    angle_out;
    logic signed [POSITION_W-1:0] turn_position;
    logic signed [SPEED_W-1:0]    speed;

    modport source (output valid, output angle_out, output turn_position, output speed,
                    input ready);
    modport sink (input valid, input angle_out, input turn_position, input speed,
                  output ready);
endinterface

[design/euv_ctrl.sv]
// Controller state machine: sequences accept, scale, divide and result load.
// Depends on euv_pkg.
module euv_ctrl
    import euv_pkg::*;
#(
    parameter int ANGLE_BITS = EUV_ANGLE_BITS
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    output logic      in_ready,
    output logic      out_valid,
    output euv_cmd_t  cmd
);

    localparam int DIV_STEPS = ANGLE_BITS + 1 + SCALE_W;
    localparam int CW        = $clog2(DIV_STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                count_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + CW'(1);
                if (count_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Load only when the output slot is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[design/euv_datapath.sv]
// Datapath: unwrap, position accumulate, scale by 1000 and serial divide.
// Depends on euv_pkg.
module euv_datapath
    import euv_pkg::*;
#(
    parameter int ANGLE_BITS = EUV_ANGLE_BITS
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  euv_cmd_t                     cmd,
    input  logic [ANGLE_SAMPLE_W-1:0]    angle_sample,
    input  logic [INTERVAL_W-1:0]        interval_ms,
    output logic [ANGLE_SAMPLE_W-1:0]    angle_out,
    output logic signed [POSITION_W-1:0] turn_position,
    output logic signed [SPEED_W-1:0]    speed
);

    localparam int DLW = ANGLE_BITS + 2;
    localparam int MW  = ANGLE_BITS + 1;
    localparam int DW  = MW + SCALE_W;

    localparam logic signed [DLW-1:0] FULL_TURN = DLW'(1) << ANGLE_BITS;
    localparam logic signed [DLW-1:0] HALF_TURN = DLW'(1) << (ANGLE_BITS - 1);

    logic [ANGLE_BITS-1:0]        last_sample_reg;
    logic [POSITION_W-1:0]        pos_reg;
    logic [ANGLE_BITS-1:0]        angle_reg;
    logic [INTERVAL_W-1:0]        interval_reg;
    logic signed [DLW-1:0]        delta_reg;
    logic [DW-1:0]                quo_reg, quo_next;
    logic [INTERVAL_W-1:0]        rem_reg, rem_next;
    logic [ANGLE_SAMPLE_W-1:0]    angle_out_reg;
    logic signed [POSITION_W-1:0] pos_out_reg;
    logic signed [SPEED_W-1:0]    speed_out_reg;

    logic [ANGLE_BITS-1:0]        cur;
    logic signed [DLW-1:0]        prev_s, cur_s, delta;
    logic signed [DLW-1:0]        abs_delta;
    logic [MW-1:0]                mag;
    logic [INTERVAL_W:0]          rem_sh;
    logic [INTERVAL_W+1:0]        trial;
    logic [SPEED_CALC_W-1:0]      q_ext, q_signed;

    // Unwrap the new sample against the previous one by the half-turn rule
    always_comb
    begin
        cur    = ANGLE_BITS'(angle_sample);
        prev_s = $signed({2'b00, last_sample_reg});
        cur_s  = $signed({2'b00, cur});
        if (prev_s > HALF_TURN && cur_s < prev_s - HALF_TURN)
        begin
            delta = FULL_TURN - prev_s + cur_s;
        end
        else if (cur_s > HALF_TURN && prev_s < cur_s - HALF_TURN)
        begin
            delta = cur_s - prev_s - FULL_TURN;
        end
        else
        begin
            delta = cur_s - prev_s;
        end
    end

    // Magnitude of the stored delta for the unsigned divide
    always_comb
    begin
        abs_delta = delta_reg[DLW-1] ? -delta_reg : delta_reg;
        mag       = MW'(abs_delta);
    end

    // Scale, then one restoring divide step per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DW-1]};
        trial    = {1'b0, rem_sh} - {2'b00, interval_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.mul)
        begin
            quo_next = DW'(mag) * DW'(SPEED_SCALE);
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[INTERVAL_W+1])
            begin
                rem_next = trial[INTERVAL_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[INTERVAL_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    // Restore the sign of the quotient
    always_comb
    begin
        q_ext    = SPEED_CALC_W'(quo_reg);
        q_signed = delta_reg[DLW-1] ? (SPEED_CALC_W'(0) - q_ext) : q_ext;
    end

    // Unwrap state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
            pos_reg         <= '0;
        end
        else if (cmd.accept)
        begin
            last_sample_reg <= cur;
            pos_reg         <= pos_reg + POSITION_W'(delta);
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            angle_reg    <= cur;
            interval_reg <= interval_ms;
            delta_reg    <= delta;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.load_out)
        begin
            angle_out_reg <= ANGLE_SAMPLE_W'(angle_reg);
            pos_out_reg   <= $signed(pos_reg);
            if (interval_reg == '0)
            begin
                speed_out_reg <= '0;
            end
            else
            begin
                speed_out_reg <= $signed(q_signed[SPEED_W-1:0]);
            end
        end
    end

    assign angle_out     = angle_out_reg;
    assign turn_position = pos_out_reg;
    assign speed         = speed_out_reg;

endmodule

[design/encoder_unwrap_velocity.sv]
// Multi-turn unwrap of an absolute angle with a velocity estimate.
// Each input word is accepted, scaled, divided and loaded into the result register; a new
// word is not accepted until the result is loaded. The bit-serial restoring divider
// produces one quotient bit per cycle over ANGLE_BITS + 11 bits.
// Reset (rst_n low, asynchronous) clears the previous sample, the position and control.
// Depends on euv_pkg, euv_in_if, euv_out_if, euv_ctrl and euv_datapath.
module encoder_unwrap_velocity
    import euv_pkg::*;
#(
    parameter int ANGLE_BITS = EUV_ANGLE_BITS
)(
    input  logic     clk,
    input  logic     rst_n,
    euv_in_if.sink   samples,
    euv_out_if.source results
);

    euv_cmd_t cmd;

    euv_ctrl #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .out_ready (results.ready),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .cmd       (cmd)
    );

    euv_datapath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .angle_sample  (samples.angle_sample),
        .interval_ms   (samples.interval_ms),
        .angle_out     (results.angle_out),
        .turn_position (results.turn_position),
        .speed         (results.speed)
    );

    // Never overwrite a result word that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!results.valid || results.ready))
        else $error("result word overwritten while pending");

    // Accept only on a real input handshake
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (samples.valid && samples.ready))
        else $error("accept without handshake");

    // Stay busy after an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !samples.ready)
        else $error("ready while an item is in progress");

endmodule
